// ===== hdl/v3nr_pkg.sv =====
`timescale 1ns / 1ps

package v3nr_pkg;

  typedef enum logic {
    OP_NORMALIZE = 1'b0,
    OP_REFLECT   = 1'b1
  } opcode_e;

endpackage

// ===== hdl/v3nr_sqrt.sv =====
`timescale 1ns / 1ps

module v3nr_sqrt #(
  parameter int W  = 32,
  parameter int TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*W-1:0]  rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [W-1:0]    root_o,
  output logic [TW-1:0]   tag_o
);

  logic           vld_q  [W];
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];
  logic [TW-1:0]  tag_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           vld_p;
    logic [W+1:0]   rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rad_p;
    logic [TW-1:0]  tag_p;
    logic [W+1:0]   rem_sh;
    logic [W+1:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign tag_p  = tag_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign tag_p  = tag_q[k-1];
    end

    assign rem_sh = {rem_p[W-1:0], rad_p[2*(W-1-k)+1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[W-2:0], ge};
        rad_q[k]  <= rad_p;
        tag_q[k]  <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign root_o  = root_q[W-1];
  assign tag_o   = tag_q[W-1];

endmodule

// ===== hdl/v3nr_div.sv =====
`timescale 1ns / 1ps

module v3nr_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  mag_i,
  input  logic [W-1:0]  den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [F:0]    quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int NS = F + 1;

  logic          vld_q [NS];
  logic [W-1:0]  rem_q [NS];
  logic [F:0]    quo_q [NS];
  logic [W-1:0]  den_q [NS];
  logic [TW-1:0] tag_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          vld_p;
    logic [W-1:0]  rem_p;
    logic [F:0]    quo_p;
    logic [W-1:0]  den_p;
    logic [TW-1:0] tag_p;
    logic          nb;
    logic [W:0]    rsh;
    logic [W:0]    dext;
    logic [W:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_p = valid_i;
      assign rem_p = {1'b0, mag_i[W-1:1]};
      assign quo_p = '0;
      assign den_p = den_i;
      assign tag_p = tag_i;
      assign nb    = mag_i[0];
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
      assign den_p = den_q[k-1];
      assign tag_p = tag_q[k-1];
      assign nb    = 1'b0;
    end

    assign rsh  = {rem_p, nb};
    assign dext = {1'b0, den_p};
    assign ge   = (rsh >= dext);
    assign diff = rsh - dext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[W-1:0] : rsh[W-1:0];
        quo_q[k] <= {quo_p[F-1:0], ge};
        den_q[k] <= den_p;
        tag_q[k] <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign tag_o   = tag_q[NS-1];

endmodule

// ===== hdl/vec3_normalize_reflect.sv =====
`timescale 1ns / 1ps

// Fixed-point 3D vector normalise / reflect, one item per cycle while not stalled.
// Input channel: in_valid_i / in_ready_o with opcode_i, vector and normal.
// Opcode normalise scales the vector to unit length; opcode reflect scales
// the normal to unit length and returns v - 2 (v . n) n.
// Output channel: out_valid_o / out_ready_i with the three result
// components, zero_length_o (vector or normal of zero length, result zero)
// and saturated_o (some component clamped to the signed range).
// Throughput: one item per cycle while the output is not stalled. The
// pipeline holds the square root pipeline (one root bit per stage,
// DATA_WIDTH stages) and the three divider lanes (FRAC_BITS + 1 stages).
// The whole pipeline advances when the output register is empty or being
// taken; while the receiver stalls with a result waiting, every stage holds
// and in_ready_o is low. Reset empties the pipeline and output register.
module vec3_normalize_reflect
  import v3nr_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic signed [DATA_WIDTH-1:0] vec_x_i,
  input  logic signed [DATA_WIDTH-1:0] vec_y_i,
  input  logic signed [DATA_WIDTH-1:0] vec_z_i,
  input  logic signed [DATA_WIDTH-1:0] norm_x_i,
  input  logic signed [DATA_WIDTH-1:0] norm_y_i,
  input  logic signed [DATA_WIDTH-1:0] norm_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] res_x_o,
  output logic signed [DATA_WIDTH-1:0] res_y_o,
  output logic signed [DATA_WIDTH-1:0] res_z_o,
  output logic                         zero_length_o,
  output logic                         saturated_o
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int UW  = F + 2;
  localparam int PW  = W + F + 2;
  localparam int PD  = W + F + 4;
  localparam int MW  = PD + F + 1;
  localparam int RW  = ((W > UW) ? W : UW) + 4;
  localparam int TWS = 6 * W + 5;
  localparam int TW0 = 3 * W + 3;

  localparam logic signed [RW-1:0] R_MAX = RW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);
  localparam logic [W-1:0] O_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] O_MIN = {1'b1, {(W-1){1'b0}}};

  logic en;

  logic signed [W-1:0] vin [3];
  logic signed [W-1:0] nin [3];

  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;
  assign nin[0] = norm_x_i;
  assign nin[1] = norm_y_i;
  assign nin[2] = norm_z_i;

  // front end: select, magnitude, square, sum
  logic                s0_vld_q, s1_vld_q, s2_vld_q;
  logic                s0_op_q, s1_op_q, s2_op_q;
  logic signed [W-1:0] s0_v_q [3];
  logic signed [W-1:0] s1_v_q [3];
  logic signed [W-1:0] s2_v_q [3];
  logic [W-1:0]        s0_mag_q [3];
  logic [W-1:0]        s1_mag_q [3];
  logic [W-1:0]        s2_mag_q [3];
  logic [2:0]          s0_neg_q, s1_neg_q, s2_neg_q;
  logic [2*W-1:0]      s1_sq_q [3];
  logic [2*W-1:0]      s2_rad_q;
  logic                s2_zero_q;

  logic [W-1:0]        s0_mag_d [3];
  logic [2:0]          s0_neg_d;
  logic [2*W-1:0]      s2_rad_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [W-1:0] sel;
      sel = (opcode_i == OP_REFLECT) ? nin[i] : vin[i];
      s0_neg_d[i] = sel[W-1];
      s0_mag_d[i] = sel[W-1] ? W'(-sel) : W'(sel);
    end
    s2_rad_d = s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q  <= opcode_i;
      s0_neg_q <= s0_neg_d;
      s1_op_q  <= s0_op_q;
      s1_neg_q <= s0_neg_q;
      s2_op_q  <= s1_op_q;
      s2_neg_q <= s1_neg_q;
      for (int i = 0; i < 3; i++) begin
        s0_v_q[i]   <= vin[i];
        s0_mag_q[i] <= s0_mag_d[i];
        s1_v_q[i]   <= s0_v_q[i];
        s1_mag_q[i] <= s0_mag_q[i];
        s1_sq_q[i]  <= (2*W)'(s0_mag_q[i]) * (2*W)'(s0_mag_q[i]);
        s2_v_q[i]   <= s1_v_q[i];
        s2_mag_q[i] <= s1_mag_q[i];
      end
      s2_rad_q  <= s2_rad_d;
      s2_zero_q <= (s2_rad_d == '0);
    end
  end

  // square root of the sum of squares
  logic [TWS-1:0] sq_tag_in, sq_tag_out;
  logic           sq_vld;
  logic [W-1:0]   sq_root;

  assign sq_tag_in = {s2_op_q, s2_zero_q, s2_neg_q,
                      s2_mag_q[0], s2_mag_q[1], s2_mag_q[2],
                      s2_v_q[0], s2_v_q[1], s2_v_q[2]};

  v3nr_sqrt #(.W(W), .TW(TWS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .rad_i   (s2_rad_q),
    .tag_i   (sq_tag_in),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag_out)
  );

  logic                sq_op, sq_zero;
  logic [2:0]          sq_neg;
  logic [W-1:0]        sq_mag [3];
  logic signed [W-1:0] sq_v [3];

  assign {sq_op, sq_zero, sq_neg, sq_mag[0], sq_mag[1], sq_mag[2],
          sq_v[0], sq_v[1], sq_v[2]} = sq_tag_out;

  // divider lanes, one per component
  logic [TW0-1:0] dv_tag0_in, dv_tag0_out;
  logic [2:0]     dv_vld;
  logic [F:0]     dv_q [3];
  logic           dv_neg1, dv_neg2;

  assign dv_tag0_in = {sq_op, sq_zero, sq_neg[0], sq_v[0], sq_v[1], sq_v[2]};

  v3nr_div #(.W(W), .F(F), .TW(TW0)) u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .mag_i   (sq_mag[0]),
    .den_i   (sq_root),
    .tag_i   (dv_tag0_in),
    .valid_o (dv_vld[0]),
    .quo_o   (dv_q[0]),
    .tag_o   (dv_tag0_out)
  );

  v3nr_div #(.W(W), .F(F), .TW(1)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .mag_i   (sq_mag[1]),
    .den_i   (sq_root),
    .tag_i   (sq_neg[1]),
    .valid_o (dv_vld[1]),
    .quo_o   (dv_q[1]),
    .tag_o   (dv_neg1)
  );

  v3nr_div #(.W(W), .F(F), .TW(1)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .mag_i   (sq_mag[2]),
    .den_i   (sq_root),
    .tag_i   (sq_neg[2]),
    .valid_o (dv_vld[2]),
    .quo_o   (dv_q[2]),
    .tag_o   (dv_neg2)
  );

  logic                dv_op, dv_zero, dv_neg0;
  logic signed [W-1:0] dv_v [3];
  logic [2:0]          dv_neg;
  logic signed [UW-1:0] dv_u [3];

  assign {dv_op, dv_zero, dv_neg0, dv_v[0], dv_v[1], dv_v[2]} = dv_tag0_out;
  assign dv_neg = {dv_neg2, dv_neg1, dv_neg0};

  // sign of lane i sits in dv_neg[i]
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_u[i] = dv_neg[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
    end
  end

  // reflect: products, dot product merge, scale
  logic                 d1_vld_q, d2_vld_q, d3_vld_q;
  logic                 d1_op_q, d2_op_q, d3_op_q;
  logic                 d1_zero_q, d2_zero_q, d3_zero_q;
  logic signed [W-1:0]  d1_v_q [3];
  logic signed [W-1:0]  d2_v_q [3];
  logic signed [W-1:0]  d3_v_q [3];
  logic signed [UW-1:0] d1_u_q [3];
  logic signed [UW-1:0] d2_u_q [3];
  logic signed [UW-1:0] d3_u_q [3];
  logic [F:0]           d1_q_q [3];
  logic [F:0]           d2_q_q [3];
  logic [2:0]           d1_neg_q, d2_neg_q, d3_tneg_q;
  logic signed [PW-1:0] d1_p_q [3];
  logic [PD-1:0]        d2_dmag_q;
  logic                 d2_dneg_q;
  logic [MW-1:0]        d3_m_q [3];

  logic signed [PD-1:0] dot;

  assign dot = PD'(d1_p_q[0]) + PD'(d1_p_q[1]) + PD'(d1_p_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_op_q   <= dv_op;
      d1_zero_q <= dv_zero;
      d1_neg_q  <= dv_neg;
      d2_op_q   <= d1_op_q;
      d2_zero_q <= d1_zero_q;
      d2_neg_q  <= d1_neg_q;
      d2_dneg_q <= dot[PD-1];
      d2_dmag_q <= dot[PD-1] ? PD'(-dot) : PD'(dot);
      d3_op_q   <= d2_op_q;
      d3_zero_q <= d2_zero_q;
      d3_tneg_q <= d2_neg_q ^ {3{d2_dneg_q}};
      for (int i = 0; i < 3; i++) begin
        d1_v_q[i] <= dv_v[i];
        d1_u_q[i] <= dv_u[i];
        d1_q_q[i] <= dv_q[i];
        d1_p_q[i] <= PW'(dv_v[i]) * PW'(dv_u[i]);
        d2_v_q[i] <= d1_v_q[i];
        d2_u_q[i] <= d1_u_q[i];
        d2_q_q[i] <= d1_q_q[i];
        d3_v_q[i] <= d2_v_q[i];
        d3_u_q[i] <= d2_u_q[i];
        d3_m_q[i] <= MW'(d2_dmag_q) * MW'(d2_q_q[i]);
      end
    end
  end

  // subtract, clamp, output register
  logic                out_vld_q, out_zero_q, out_sat_q;
  logic signed [W-1:0] out_res_q [3];
  logic signed [W-1:0] res_d [3];
  logic                sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      logic [W+1:0]         t_mag;
      logic signed [RW-1:0] t_s;
      logic signed [RW-1:0] r;
      t_mag = d3_m_q[i][2*F-1 +: W+2];
      t_s   = RW'($signed({1'b0, t_mag}));
      if (d3_tneg_q[i]) begin
        t_s = -t_s;
      end
      r = (d3_op_q == OP_REFLECT) ? (RW'(d3_v_q[i]) - t_s) : RW'(d3_u_q[i]);
      if (r > R_MAX) begin
        res_d[i] = O_MAX;
        sat_d    = 1'b1;
      end else if (r < R_MIN) begin
        res_d[i] = O_MIN;
        sat_d    = 1'b1;
      end else begin
        res_d[i] = r[W-1:0];
      end
      if (d3_zero_q) begin
        res_d[i] = '0;
      end
    end
    if (d3_zero_q) begin
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_zero_q <= d3_zero_q;
      out_sat_q  <= sat_d;
      for (int i = 0; i < 3; i++) begin
        out_res_q[i] <= res_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      d1_vld_q  <= 1'b0;
      d2_vld_q  <= 1'b0;
      d3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= in_valid_i;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      d1_vld_q  <= dv_vld[0];
      d2_vld_q  <= d1_vld_q;
      d3_vld_q  <= d2_vld_q;
      out_vld_q <= d3_vld_q;
    end
  end

  assign en            = !out_vld_q || out_ready_i;
  assign in_ready_o    = en;
  assign out_valid_o   = out_vld_q;
  assign res_x_o       = out_res_q[0];
  assign res_y_o       = out_res_q[1];
  assign res_z_o       = out_res_q[2];
  assign zero_length_o = out_zero_q;
  assign saturated_o   = out_sat_q;

  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld[0] == dv_vld[1]) && (dv_vld[0] == dv_vld[2]))
    else $error("divider lanes out of step");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_length_o) |->
      (res_x_o == '0 && res_y_o == '0 && res_z_o == '0 && !saturated_o))
    else $error("zero-length item with non-zero result");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (res_x_o == O_MAX || res_x_o == O_MIN || res_y_o == O_MAX ||
       res_y_o == O_MIN || res_z_o == O_MAX || res_z_o == O_MIN))
    else $error("saturated flag without a clamped component");

endmodule
